[rtl/upc_pkg.sv]
// shared types, character constants and helper functions for the percent codec
// used by every module of url_percent_codec_core; no dependencies
package upc_pkg;

  // characters with a role of their own
  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // escape progress in decode mode
  localparam logic [1:0] HELD_NONE    = 2'd0;
  localparam logic [1:0] HELD_PERCENT = 2'd1;
  localparam logic [1:0] HELD_DIGIT   = 2'd2;

  // one group of one to three result bytes, as worked out by the front
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       eom;
    logic       bad;
  } cmd_t;

  // queue status seen by back and top
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // letters, digits, dash and underscore pass through the encoder
  function automatic logic is_safe(input logic [7:0] b);
    logic safe;
    safe = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
           (b == CHAR_DASH) || (b == CHAR_UNDERSCORE);
    return safe;
  endfunction

  // bit 4 set when b is a hex digit of either case, bits 3:0 its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      v = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      v = {1'b1, 4'(b - 8'h37)};
    end else if (b inside {[8'h61:8'h66]}) begin
      v = {1'b1, 4'(b - 8'h57)};
    end
    return v;
  endfunction

  // upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h37 + {4'd0, n};
    end
    return c;
  endfunction

endpackage

[rtl/url_percent_codec_core.sv]
// Percent codec for a byte stream. A direction bit selects encoding (letters,
// digits, dash and underscore pass, other bytes become a percent sign and two
// upper-case hex digits) or decoding (percent plus two hex digits becomes one
// byte, a short escape at message end passes literally, a non-hex escape passes
// literally with bad_escape on its percent sign). An escaped byte in encode mode
// yields three result bytes; the result side delivers one item per cycle while
// pop is high and the queue is not empty. A queue of DEPTH result groups lets
// input and output stall independently; full rises when it holds DEPTH groups.
// Write the direction only while idle: the write drops any partial escape.
// depends on upc_pkg, upc_front, upc_queue and upc_back
module url_percent_codec_core
  import upc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_escape
);

  logic                       accept;
  logic                       cmd_push;
  cmd_t                       cmd;
  cmd_t                       head;
  q_status_t                  q_status;
  logic                       head_done;
  logic                       direction;
  logic [$clog2(DEPTH+1)-1:0] q_level;

  assign full   = q_status.full;
  assign empty  = q_status.empty;
  assign accept = push && !q_status.full;

  // classification
  upc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .cmd_push       (cmd_push),
    .cmd            (cmd),
    .direction      (direction)
  );

  // group queue
  upc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .wdata  (cmd),
    .pop    (head_done),
    .rdata  (head),
    .status (q_status),
    .level  (q_level)
  );

  // result sequencing
  upc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .head_done  (head_done),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_escape (bad_escape)
  );

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");

  a_bad_on_percent: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_escape) |-> (out_byte == CHAR_PERCENT && !out_last &&
                                direction == DIR_DECODE))
    else $error("bad_escape on a wrong item");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("queue level beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !cmd_push)
    else $error("group pushed into full queue");

endmodule

[rtl/upc_front.sv]
// front part of the percent codec: direction register, escape tracking and
// classification of each accepted item into a result group; uses upc_pkg
module upc_front
  import upc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       cmd_push,
  output cmd_t       cmd,
  output logic       direction
);

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic [4:0] hi_val;
  logic [4:0] lo_val;

  assign hi_val = hex_value(held_digit);
  assign lo_val = hex_value(data_byte);

  // classify the incoming byte
  always_comb begin
    cmd             = '0;
    cmd.eom         = end_of_message;
    held_count_next = held_count;
    held_digit_next = held_digit;
    if (direction == DIR_ENCODE) begin
      if (is_safe(data_byte)) begin
        cmd.cnt = 2'd1;
        cmd.b0  = data_byte;
      end else begin
        cmd.cnt = 2'd3;
        cmd.b0  = CHAR_PERCENT;
        cmd.b1  = hex_char(data_byte[7:4]);
        cmd.b2  = hex_char(data_byte[3:0]);
      end
    end else begin
      case (held_count)
        HELD_PERCENT: begin
          if (end_of_message) begin
            // short escape at message end goes out literally
            held_count_next = HELD_NONE;
            held_digit_next = 8'd0;
            cmd.cnt         = 2'd2;
            cmd.b0          = CHAR_PERCENT;
            cmd.b1          = data_byte;
          end else begin
            held_count_next = HELD_DIGIT;
            held_digit_next = data_byte;
          end
        end
        HELD_DIGIT: begin
          held_count_next = HELD_NONE;
          held_digit_next = 8'd0;
          if (hi_val[4] && lo_val[4]) begin
            cmd.cnt = 2'd1;
            cmd.b0  = {hi_val[3:0], lo_val[3:0]};
          end else begin
            // non-hex escape goes out literally, flagged on the percent
            cmd.cnt = 2'd3;
            cmd.b0  = CHAR_PERCENT;
            cmd.b1  = held_digit;
            cmd.b2  = data_byte;
            cmd.bad = 1'b1;
          end
        end
        default: begin
          held_count_next = HELD_NONE;
          if (data_byte == CHAR_PERCENT && !end_of_message) begin
            held_count_next = HELD_PERCENT;
          end else begin
            cmd.cnt = 2'd1;
            cmd.b0  = data_byte;
          end
        end
      endcase
    end
  end

  assign cmd_push = accept && (cmd.cnt != 2'd0);

  // direction register and escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= DIR_ENCODE;
      held_count <= HELD_NONE;
      held_digit <= 8'd0;
    end else if (cfg_we) begin
      direction  <= cfg_wdata;
      held_count <= HELD_NONE;
      held_digit <= 8'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

[rtl/upc_queue.sv]
// short command queue between front and back, held in registers
// depends on upc_pkg for the command and status types
module upc_queue
  import upc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  cmd_t                       wdata,
  input  logic                       pop,
  output cmd_t                       rdata,
  output q_status_t                  status,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = entries[rd_ptr];
  assign level        = count;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/upc_back.sv]
// back part of the percent codec: steps through the bytes of the group at the
// head of the command queue, one result item per pop; uses upc_pkg
module upc_back
  import upc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  q_status_t  q_status,
  input  logic       pop,
  output logic       head_done,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_escape
);

  logic [1:0] idx;
  logic       final_byte;
  logic       taken;

  assign final_byte = (idx == head.cnt - 2'd1);
  assign taken      = pop && !q_status.empty;
  assign head_done  = taken && final_byte;

  // select the current byte of the group
  always_comb begin
    case (idx)
      2'd0:    out_byte = head.b0;
      2'd1:    out_byte = head.b1;
      default: out_byte = head.b2;
    endcase
  end

  assign out_last   = head.eom && final_byte;
  assign bad_escape = head.bad && (idx == 2'd0);

  // byte index within the group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (taken) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

[sim/tb_url_percent_codec_core.sv]
`timescale 1ns / 100ps
// self-checking testbench for url_percent_codec_core: directed and random byte streams
// in both directions, checked against a scoreboard that predicts every result byte
// depends on upc_pkg and url_percent_codec_core
module tb_url_percent_codec_core
  import upc_pkg::*;
();

  localparam int SETTLE_CYCLES = 8;
  localparam int CHUNK_ITEMS   = 55;
  localparam int NUM_CHUNKS    = 6;

  // one result byte as the block should deliver it
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       bad;
  } codec_byte_t;

  // predicts the converted stream and checks delivered bytes in order
  class percent_scoreboard;
    codec_byte_t pending_bytes[$];
    logic        direction;
    logic [1:0]  held_count;
    logic [7:0]  held_digit;
    int          errors;

    function new();
      direction  = DIR_ENCODE;
      held_count = HELD_NONE;
      held_digit = 8'h00;
      errors     = 0;
    endfunction

    static function logic [7:0] hex_digit(input logic [3:0] n);
      string digits;
      digits = "0123456789ABCDEF";
      return digits[n];
    endfunction

    static function bit unreserved(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
             (b >= "a" && b <= "z") || b == CHAR_DASH || b == CHAR_UNDERSCORE;
    endfunction

    // returns 1 when b is a hex digit of either case, with its value in n
    static function bit read_hex(input logic [7:0] b, output logic [3:0] n);
      n = 4'h0;
      if (b >= "0" && b <= "9") begin
        n = b[3:0];
        return 1'b1;
      end
      if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
        n = b[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void expect_byte(input logic [7:0] v, input logic last, input logic bad);
      codec_byte_t e;
      e.value = v;
      e.last  = last;
      e.bad   = bad;
      pending_bytes.push_back(e);
    endfunction

    // a direction write drops any escape in progress
    function void set_direction(input logic d);
      direction  = d;
      held_count = HELD_NONE;
      held_digit = 8'h00;
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction

    // works out the result bytes of one accepted item
    function void predict_item(input logic [7:0] b, input logic eom);
      logic [3:0] hi;
      logic [3:0] lo;
      bit         hi_ok;
      bit         lo_ok;
      if (direction == DIR_ENCODE) begin
        if (unreserved(b)) begin
          expect_byte(b, eom, 1'b0);
        end else begin
          expect_byte(CHAR_PERCENT, 1'b0, 1'b0);
          expect_byte(hex_digit(b[7:4]), 1'b0, 1'b0);
          expect_byte(hex_digit(b[3:0]), eom, 1'b0);
        end
        return;
      end
      case (held_count)
        HELD_PERCENT: begin
          // short escape at message end goes out literally
          if (eom) begin
            set_direction(direction);
            expect_byte(CHAR_PERCENT, 1'b0, 1'b0);
            expect_byte(b, 1'b1, 1'b0);
          end else begin
            held_digit = b;
            held_count = HELD_DIGIT;
          end
        end
        HELD_DIGIT: begin
          hi_ok = read_hex(held_digit, hi);
          lo_ok = read_hex(b, lo);
          if (hi_ok && lo_ok) begin
            expect_byte({hi, lo}, eom, 1'b0);
          end else begin
            expect_byte(CHAR_PERCENT, 1'b0, 1'b1);
            expect_byte(held_digit, 1'b0, 1'b0);
            expect_byte(b, eom, 1'b0);
          end
          set_direction(direction);
        end
        default: begin
          held_count = HELD_NONE;
          if (b == CHAR_PERCENT && !eom) begin
            held_count = HELD_PERCENT;
          end else begin
            expect_byte(b, eom, 1'b0);
          end
        end
      endcase
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_byte(input logic [7:0] v, input logic last, input logic bad);
      codec_byte_t e;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %b bad %b", v, last, bad));
        return;
      end
      e = pending_bytes.pop_front();
      if (v !== e.value) begin
        report_mismatch($sformatf("out_byte %02h, wanted %02h", v, e.value));
      end
      if (last !== e.last) begin
        report_mismatch($sformatf("out_last %b on byte %02h, wanted %b", last, e.value, e.last));
      end
      if (bad !== e.bad) begin
        report_mismatch($sformatf("bad_escape %b on byte %02h, wanted %b", bad, e.value, e.bad));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_escape;

  int send_idle;
  int recv_idle;
  percent_scoreboard sb;

  url_percent_codec_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .bad_escape    (bad_escape)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, checks every byte taken
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99, 0) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_byte(out_byte, out_last, bad_escape);
    end
  end

  // offers one item after random idle cycles; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] b, input logic eom);
    while ($urandom_range(99, 0) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.predict_item(b, eom);
    @(negedge clk);
  endtask

  // sends a string as one message, end marked on its final character
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  // holds the sender off until every expected byte has come out
  task automatic wait_until_drained(input int settle);
    push <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_direction(input logic d);
    wait_until_drained(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_direction(d);
  endtask

  function automatic logic [7:0] random_hex_char();
    logic [7:0] c;
    c = percent_scoreboard::hex_digit(4'($urandom_range(15, 0)));
    // letters in lower case half the time
    if (c >= "A" && $urandom_range(1, 0) == 1) begin
      c = c | 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] random_safe_char();
    int r;
    r = $urandom_range(63, 0);
    if (r < 10) return 8'(r) + "0";
    if (r < 36) return 8'(r - 10) + "A";
    if (r < 62) return 8'(r - 36) + "a";
    return (r == 62) ? CHAR_DASH : CHAR_UNDERSCORE;
  endfunction

  // builds and sends one random message; returns the number of items sent
  task automatic send_random_message(input logic d, output int n);
    logic [7:0] msg[$];
    int         tokens;
    int         r;
    tokens = $urandom_range(6, 1);
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(99, 0);
      if (d == DIR_ENCODE) begin
        msg.push_back(r < 50 ? random_safe_char() : 8'($urandom_range(255, 0)));
      end else if (r < 45) begin
        // well-formed escape
        msg.push_back(CHAR_PERCENT);
        msg.push_back(random_hex_char());
        msg.push_back(random_hex_char());
      end else if (r < 60) begin
        // escape that is most likely broken
        msg.push_back(CHAR_PERCENT);
        msg.push_back($urandom_range(1, 0) ? random_hex_char() : 8'($urandom_range(255, 0)));
        msg.push_back(8'($urandom_range(255, 0)));
      end else if (r < 92) begin
        msg.push_back(8'($urandom_range(255, 0)));
      end else begin
        msg.push_back(CHAR_PERCENT);
      end
    end
    // short escape at the message end now and then
    if (d == DIR_DECODE) begin
      r = $urandom_range(99, 0);
      if (r < 15) begin
        msg.push_back(CHAR_PERCENT);
      end else if (r < 25) begin
        msg.push_back(CHAR_PERCENT);
        msg.push_back(random_hex_char());
      end
    end
    n = msg.size();
    for (int i = 0; i < n; i++) begin
      send_item(msg[i], i == n - 1);
    end
  endtask

  // stimulus
  initial begin
    logic [7:0] edge_bytes[$];
    int         chunk_items;
    int         n;
    logic       d;
    sb             = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    push           = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    send_idle      = 16;
    recv_idle      = 88;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed encode: field extremes and the pass-through class boundaries
    write_direction(DIR_ENCODE);
    edge_bytes = '{8'h00, 8'hFF, "0", "A", "a", "z", CHAR_DASH, CHAR_UNDERSCORE,
                   CHAR_PERCENT, 8'h80};
    foreach (edge_bytes[i]) begin
      send_item(edge_bytes[i], i == 1 || i == edge_bytes.size() - 1);
    end

    // directed decode: good, lower case, non-hex and short escapes
    write_direction(DIR_DECODE);
    send_text("%41");
    send_text("%2f");
    send_text("%G1");
    send_text("%");
    send_text("%4");
    // direction write in the middle of an escape drops it
    send_item(CHAR_PERCENT, 1'b0);
    send_item("4", 1'b0);
    write_direction(DIR_DECODE);
    send_item("1", 1'b1);

    // random messages, alternating direction, three idling profiles
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      if (chunk == 2) begin
        send_idle = 88;
        recv_idle = 16;
      end else if (chunk == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      d = (chunk % 2 == 0) ? DIR_ENCODE : DIR_DECODE;
      write_direction(d);
      chunk_items = 0;
      while (chunk_items < CHUNK_ITEMS) begin
        send_random_message(d, n);
        chunk_items += n;
        if ($urandom_range(19, 0) == 0) begin
          wait_until_drained(0);
        end
      end
    end

    wait_until_drained(4 * SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/upc_pkg.sv
rtl/upc_front.sv
rtl/upc_queue.sv
rtl/upc_back.sv
rtl/url_percent_codec_core.sv
sim/tb_url_percent_codec_core.sv
